@@ hw/rtl/ype_pkg.sv @@
// ----------------------------------------------------------------------------
// ype_pkg
// shared types and constants of the yin pitch estimator
// ----------------------------------------------------------------------------
package ype_pkg;

  // default sizes of the window and the sample store
  localparam int MAX_WINDOW_DEF  = 2048;
  localparam int STORE_DEPTH_DEF = 8192;

  // field and register widths
  localparam int SAMPLE_W = 16;
  localparam int LAG_W    = 12;
  localparam int RATE_W   = 18;
  localparam int Q_W      = 24;
  localparam int FRAC_W   = 16;
  localparam int SQ_W     = 32;
  localparam int SUM_W    = LAG_W + SQ_W;
  localparam int PROD_W   = SUM_W + LAG_W;
  localparam int TOTAL_W  = 64;
  localparam int DEN_W    = Q_W + 2;
  localparam int NUM_W    = RATE_W + DEN_W + 5;
  localparam int DIV_W    = LAG_W + DEN_W + 3;
  localparam int DVD_W    = PROD_W + FRAC_W;
  localparam int CNT_W    = $clog2(DVD_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [Q_W-1:0] SAT24 = 24'hFFFFFF;
  localparam logic [Q_W-1:0] Q_ONE = 24'h010000;

  // register reset values
  localparam logic [RATE_W-1:0] RATE_RST   = 18'd48000;
  localparam logic [LAG_W-1:0]  WIN_RST    = 12'd1201;
  localparam logic [LAG_W-1:0]  MINLAG_RST = 12'd48;
  localparam logic [Q_W-1:0]    THR_RST    = 24'd6554;
  localparam logic [15:0]       LIMIT_RST  = 16'd3277;
  localparam logic [15:0]       GAIN_RST   = 16'd32768;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_RATE   = 3'd0,
    CFG_WINDOW_LEN    = 3'd1,
    CFG_MIN_LAG       = 3'd2,
    CFG_DIP_THRESHOLD = 3'd3,
    CFG_SMOOTH_LIMIT  = 3'd4,
    CFG_SMOOTH_GAIN   = 3'd5
  } cfg_index_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SUM, S_MUL, S_RLOAD, S_RDIV, S_RDONE, S_DIP1,
    S_DIP2, S_FLOAD, S_FDIV, S_FDONE, S_SM1, S_SM2, S_SM3, S_FINISH
  } state_t;

endpackage

@@ hw/rtl/yin_pitch_estimator.sv @@
// ----------------------------------------------------------------------------
// yin_pitch_estimator
// yin style pitch estimator over a circular sample store
// ----------------------------------------------------------------------------
// Usage: audio samples enter as words on the s_ channel, one result word
// leaves on the m_ channel per sample: the last published pitch in 1/16 Hz
// (zero for none) and a flag that marks the end of a window. The user must
// write settings (cfg_we / cfg_index / cfg_data) only while idle (unenforced).
// Flow: one sample at a time. A sample that does not search goes from
// accept through the finish state to the result register. A searching
// sample walks w stored pairs (w = window length) through the two read
// ports of the sample store, one pair per cycle, then the ratio divider
// runs; at or above the minimum lag a dip check follows, and a dip runs the
// divider again for refinement and then goes through smoothing.
// Reset: the store is swept to zero, one entry per cycle, with s_tready
// low; configuration writes are taken meanwhile.
// Stall: the result sits in an output register; the next sample is taken
// and worked on, and its result waits until the register is taken.
// ----------------------------------------------------------------------------
module yin_pitch_estimator
  import ype_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [Q_W-1:0]        m_tdata,   // [23:0] pitch
  output logic [0:0]            m_tuser,   // [0] window_done
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);

  state_t state, state_next;

  // configuration
  logic [RATE_W-1:0] sample_rate;
  logic [LAG_W-1:0]  window_len, min_lag;
  logic [Q_W-1:0]    dip_threshold;
  logic [15:0]       smooth_limit, smooth_gain;

  // estimator state
  logic [AW-1:0]      window_base, clr_addr;
  logic [LAG_W-1:0]   lag, pos, w;
  logic [TOTAL_W-1:0] total;
  logic [Q_W-1:0]     r0, r1, r2;
  logic [Q_W-1:0]     found_pitch, published_pitch;

  // sum pipeline
  logic                 v1, v2;
  logic [SQ_W-1:0]      sq;
  logic [SUM_W-1:0]     sum;
  logic [PROD_W-1:0]    prod;
  logic signed [SAMPLE_W:0]     diff;
  logic signed [2*SAMPLE_W+1:0] sq_full;

  // shared divider
  logic [DVD_W-1:0]   dvd;
  logic [TOTAL_W-1:0] dvs, rem;
  logic [Q_W:0]       quo;
  logic               ovf;
  logic [CNT_W-1:0]   cnt;
  logic [TOTAL_W:0]   trial;
  logic               ge;
  logic [Q_W-1:0]     qsat;

  // dip refinement and smoothing
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] num;
  logic [DIV_W-1:0] dnm;
  logic [Q_W-1:0]   fq, dlt, step;
  logic             up, smooth;

  // sample store
  logic [SAMPLE_W-1:0] store [STORE_DEPTH];
  logic [SAMPLE_W-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0]       rd_a, rd_b, waddr;
  logic [SAMPLE_W-1:0] wdata;
  logic                mem_we, accept, issue, out_free;

  // effective window length
  always_comb begin
    if (32'(window_len) > MAX_WINDOW) w = LAG_W'(MAX_WINDOW);
    else w = window_len;
  end

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign issue    = (state == S_SUM) && (pos < w);
  assign rd_a     = window_base + AW'(pos);
  assign rd_b     = rd_a + AW'(lag);

  // store write: clearing sweep or incoming sample
  always_comb begin
    mem_we = 1'b0;
    waddr  = clr_addr;
    wdata  = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept) begin
      mem_we = 1'b1;
      waddr  = window_base + AW'(w) + AW'(lag) - AW'(1);
      wdata  = s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) store[waddr] <= wdata;
    rd_a_q <= store[rd_a];
    rd_b_q <= store[rd_b];
  end

  // divider step and saturation
  assign trial = {rem, dvd[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign qsat  = (ovf || quo[Q_W]) ? SAT24 : quo[Q_W-1:0];

  assign diff    = $signed({rd_a_q[SAMPLE_W-1], rd_a_q}) - $signed({rd_b_q[SAMPLE_W-1], rd_b_q});
  assign sq_full = diff * diff;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      S_CLEAR: if (clr_addr == '1) state_next = S_IDLE;
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (lag <= LAG_W'(1)) state_next = S_FINISH;
          else if (found_pitch == '0) state_next = S_SUM;
          else state_next = S_FINISH;
        end
      end
      S_SUM:   if (pos == w && !v1 && !v2) state_next = S_MUL;
      S_MUL:   state_next = S_RLOAD;
      S_RLOAD: state_next = S_RDIV;
      S_RDIV:  if (cnt == CNT_W'(DVD_W - 1)) state_next = S_RDONE;
      S_RDONE: state_next = (lag >= min_lag) ? S_DIP1 : S_FINISH;
      S_DIP1: begin
        if (r1 < dip_threshold && r2 > r1 && r0 >= r1) state_next = S_DIP2;
        else state_next = S_FINISH;
      end
      S_DIP2:  state_next = S_FLOAD;
      S_FLOAD: state_next = S_FDIV;
      S_FDIV:  if (cnt == CNT_W'(DVD_W - 1)) state_next = S_FDONE;
      S_FDONE: state_next = S_SM1;
      S_SM1:   state_next = S_SM2;
      S_SM2:   state_next = S_SM3;
      S_SM3:   state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate   <= RATE_RST;
      window_len    <= WIN_RST;
      min_lag       <= MINLAG_RST;
      dip_threshold <= THR_RST;
      smooth_limit  <= LIMIT_RST;
      smooth_gain   <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_RATE:   sample_rate   <= cfg_data[RATE_W-1:0];
        CFG_WINDOW_LEN:    window_len    <= cfg_data[LAG_W-1:0];
        CFG_MIN_LAG:       min_lag       <= cfg_data[LAG_W-1:0];
        CFG_DIP_THRESHOLD: dip_threshold <= cfg_data[Q_W-1:0];
        CFG_SMOOTH_LIMIT:  smooth_limit  <= cfg_data[15:0];
        CFG_SMOOTH_GAIN:   smooth_gain   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr        <= '0;
      window_base     <= '0;
      lag             <= LAG_W'(1);
      found_pitch     <= '0;
      published_pitch <= '0;
      m_tvalid        <= 1'b0;
      v1              <= 1'b0;
      v2              <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      if (m_tvalid && m_tready && state != S_FINISH) m_tvalid <= 1'b0;
      unique case (state)
        S_CLEAR: clr_addr <= clr_addr + AW'(1);
        S_IDLE: if (accept && lag <= LAG_W'(1)) found_pitch <= '0;
        S_SM3: begin
          if (smooth) found_pitch <= up ? published_pitch + step : published_pitch - step;
          else found_pitch <= fq;
        end
        S_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (lag == w) published_pitch <= found_pitch;
            if (lag >= w) begin
              lag         <= LAG_W'(1);
              window_base <= window_base + AW'(w);
            end else begin
              lag <= lag + LAG_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (v1) sq <= sq_full[SQ_W-1:0];
    if (v2) sum <= sum + SUM_W'(sq);
    if (issue) pos <= pos + LAG_W'(1);
    unique case (state)
      S_IDLE: begin
        pos <= '0;
        sum <= '0;
        if (accept && lag <= LAG_W'(1)) begin
          total <= '0;
          r0    <= '0;
          r1    <= Q_ONE;
          r2    <= '0;
        end
      end
      S_MUL: begin
        total <= total + TOTAL_W'(sum);
        prod  <= PROD_W'(sum) * PROD_W'(lag);
      end
      S_RLOAD, S_FLOAD: begin
        if (state == S_RLOAD) begin
          dvd <= {prod, FRAC_W'(0)};
          dvs <= total;
        end else begin
          dvd <= DVD_W'(num) + DVD_W'(dnm >> 1);
          dvs <= TOTAL_W'(dnm);
        end
        rem <= '0;
        quo <= '0;
        ovf <= 1'b0;
        cnt <= '0;
      end
      S_RDIV, S_FDIV: begin
        dvd <= dvd << 1;
        rem <= ge ? TOTAL_W'(trial - {1'b0, dvs}) : trial[TOTAL_W-1:0];
        quo <= {quo[Q_W-1:0], ge};
        ovf <= ovf | quo[Q_W];
        cnt <= cnt + CNT_W'(1);
      end
      S_RDONE: begin
        r0 <= r1;
        r1 <= r2;
        r2 <= qsat;
      end
      S_DIP1: den <= DEN_W'(r0) + DEN_W'(r2) - (DEN_W'(r1) << 1);
      S_DIP2: begin
        num <= NUM_W'(NUM_W'(sample_rate) * NUM_W'(den)) << 5;
        dnm <= ((DIV_W'(lag - LAG_W'(1)) * DIV_W'(den)) << 1) + DIV_W'(r0) - DIV_W'(r2);
      end
      S_FDONE: fq <= qsat;
      S_SM1: begin
        up  <= fq >= published_pitch;
        dlt <= (fq >= published_pitch) ? fq - published_pitch : published_pitch - fq;
      end
      S_SM2: begin
        smooth <= (published_pitch != '0) && (fq != '0) &&
                  ({dlt, 16'b0} < 40'(smooth_limit) * 40'(fq));
        step   <= Q_W'((40'(dlt) * 40'(smooth_gain) + 40'h8000) >> 16);
      end
      S_FINISH: begin
        if (out_free) begin
          m_tdata    <= (lag == w) ? found_pitch : published_pitch;
          m_tuser[0] <= (lag == w);
        end
      end
      default: ;
    endcase
  end

  // no sample taken during the clearing sweep
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("sample taken during store clear");

  // divider remainder stays below a nonzero divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RDIV || state == S_FDIV) && dvs != '0) |-> (rem < dvs))
    else $error("divider remainder out of range");

  // a result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result overwritten while stalled");

  // lag counter never reaches zero
  a_lag_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (lag != '0))
    else $error("lag counter at zero");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the yin pitch estimator
// ----------------------------------------------------------------------------
// Audio words go in on the s_ channel in random bursts. A bit-accurate
// pitch tracker inside the bench predicts each result word, and the monitor
// compares it with the block's output. Settings change between phases, only
// once the block has drained.
// ----------------------------------------------------------------------------
module tb_top;
  import ype_pkg::*;

  localparam int WIN_CAP    = 2048;
  localparam int STORE_SIZE = 8192;
  localparam int CYCLE_CAP  = 3000000;

  typedef struct packed {
    logic [Q_W-1:0] pitch;
    logic           window_done;
  } pitch_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [Q_W-1:0]        m_tdata;
  logic [0:0]            m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SAMPLE_RATE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  yin_pitch_estimator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // tracker settings and state
  logic [RATE_W-1:0]   trk_rate   = RATE_RST;
  logic [LAG_W-1:0]    trk_window = WIN_RST;
  logic [LAG_W-1:0]    trk_minlag = MINLAG_RST;
  logic [Q_W-1:0]      trk_thresh = THR_RST;
  logic [15:0]         trk_limit  = LIMIT_RST;
  logic [15:0]         trk_gain   = GAIN_RST;
  logic [SAMPLE_W-1:0] audio_mem [STORE_SIZE];
  int unsigned         win_base = 0;
  int unsigned         cur_lag  = 1;
  longint unsigned     diff_total = 0;
  longint unsigned     ratio_hist [3];
  longint unsigned     found_freq = 0;
  longint unsigned     shown_freq = 0;

  logic [SAMPLE_W-1:0] sample_queue [$];
  pitch_word_t         pitch_queue [$];
  int                  err_count = 0;
  int                  cycle_count = 0;
  int                  burst_left = 0;
  int                  gap_left = 0;
  logic [7:0]          ready_mask = 8'hFF;
  int unsigned         ready_bit = 0;

  initial begin
    foreach (audio_mem[i]) audio_mem[i] = '0;
    foreach (ratio_hist[i]) ratio_hist[i] = 0;
  end

  function automatic longint signed audio_at(int unsigned addr);
    return longint'($signed(audio_mem[addr & (STORE_SIZE - 1)]));
  endfunction

  // normalized difference in Q8.16, long division with saturation
  function automatic longint unsigned norm_ratio(longint unsigned sum, int unsigned k,
                                                 longint unsigned total);
    longint unsigned n, q, rem;
    if (total == 0) return SAT24;
    n = sum * k;
    q = n / total;
    if (q >= 256) return SAT24;
    rem = n % total;
    for (int i = 0; i < FRAC_W; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= total) begin
        rem = rem - total;
        q = q | 1;
      end
    end
    return (q > SAT24) ? SAT24 : q;
  endfunction

  // dip test, parabolic refinement and smoothing toward the shown pitch
  task automatic check_dip(int unsigned k);
    longint unsigned r1, r2, r3, den, num, dv, f, prev, d, stp;
    r1 = ratio_hist[0];
    r2 = ratio_hist[1];
    r3 = ratio_hist[2];
    if (!(r2 < trk_thresh && r3 > r2 && r1 >= r2)) return;
    den = r1 + r3 - 2 * r2;
    num = longint'(trk_rate) * 32 * den;
    dv = longint'(k - 1) * 2 * den + r1 - r3;
    f = (num + dv / 2) / dv;
    if (f > SAT24) f = SAT24;
    prev = shown_freq;
    if (prev > 0 && f > 0) begin
      d = (f >= prev) ? f - prev : prev - f;
      if ((d << 16) < longint'(trk_limit) * f) begin
        stp = (d * trk_gain + 64'h8000) >> 16;
        f = (f >= prev) ? prev + stp : prev - stp;
      end
    end
    found_freq = f;
  endtask

  // one accepted sample through the tracker
  task automatic track_sample(logic [SAMPLE_W-1:0] smp, output pitch_word_t res);
    int unsigned w;
    longint unsigned sum;
    longint signed d;
    w = (trk_window > WIN_CAP) ? WIN_CAP : trk_window;
    audio_mem[(win_base + w + cur_lag - 1) & (STORE_SIZE - 1)] = smp;
    res.window_done = 1'b0;
    if (cur_lag <= 1) begin
      found_freq = 0;
      diff_total = 0;
      ratio_hist[0] = 0;
      ratio_hist[1] = Q_ONE;
      ratio_hist[2] = 0;
    end else if (found_freq == 0) begin
      sum = 0;
      for (int unsigned p = 0; p < w; p++) begin
        d = audio_at(win_base + p) - audio_at(win_base + p + cur_lag);
        sum += longint'(d * d);
      end
      diff_total += sum;
      ratio_hist[0] = ratio_hist[1];
      ratio_hist[1] = ratio_hist[2];
      ratio_hist[2] = norm_ratio(sum, cur_lag, diff_total);
      if (cur_lag >= trk_minlag) check_dip(cur_lag);
    end
    if (cur_lag == w) begin
      shown_freq = found_freq;
      res.window_done = 1'b1;
    end
    if (cur_lag >= w) begin
      cur_lag = 1;
      win_base = (win_base + w) & (STORE_SIZE - 1);
    end else begin
      cur_lag++;
    end
    res.pitch = shown_freq[Q_W-1:0];
  endtask

  // sender: bursts with random gaps, tracker fed on each accepted word
  always @(posedge clk) begin
    pitch_word_t res;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_sample(s_tdata, res);
        pitch_queue.push_back(res);
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          s_tdata  <= sample_queue.pop_front();
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    m_tready  <= rst ? 1'b0 : ready_mask[ready_bit[2:0]];
    ready_bit <= ready_bit + 1;
  end

  // result check against the oldest prediction
  always @(posedge clk) begin
    pitch_word_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (pitch_queue.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected word: pitch %0d done %0d", m_tdata, m_tuser);
      end else begin
        want = pitch_queue.pop_front();
        if (want.pitch !== m_tdata || want.window_done !== m_tuser[0]) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: pitch exp %0d got %0d, done exp %0d got %0d",
                     want.pitch, m_tdata, want.window_done, m_tuser);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_CAP) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_index_t idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    case (idx)
      CFG_SAMPLE_RATE:   trk_rate   = val[RATE_W-1:0];
      CFG_WINDOW_LEN:    trk_window = val[LAG_W-1:0];
      CFG_MIN_LAG:       trk_minlag = val[LAG_W-1:0];
      CFG_DIP_THRESHOLD: trk_thresh = val[Q_W-1:0];
      CFG_SMOOTH_LIMIT:  trk_limit  = val[15:0];
      CFG_SMOOTH_GAIN:   trk_gain   = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(int unsigned rate, int unsigned win, int unsigned ml,
                         int unsigned thr, int unsigned lim, int unsigned gain);
    write_reg(CFG_SAMPLE_RATE, rate);
    write_reg(CFG_WINDOW_LEN, win);
    write_reg(CFG_MIN_LAG, ml);
    write_reg(CFG_DIP_THRESHOLD, thr);
    write_reg(CFG_SMOOTH_LIMIT, lim);
    write_reg(CFG_SMOOTH_GAIN, gain);
  endtask

  // wait until the block has drained, checked between clock edges
  task automatic drain();
    while (sample_queue.size() > 0 || pitch_queue.size() > 0 || s_tvalid)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  // periodic ramp with a little noise, or plain noise
  task automatic queue_tone(int n, int per, int amp, int noise);
    int v;
    for (int i = 0; i < n; i++) begin
      v = (per > 0) ? (amp * (2 * (i % per) - per)) / per : 0;
      if (noise > 0) v += $urandom_range(0, 2 * noise) - noise;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      sample_queue.push_back(v[15:0]);
    end
  endtask

  initial begin
    int win, per;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // extremes of the sample at the reset settings
    ready_mask = 8'hFF;
    sample_queue = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE,
                     16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF, 16'h0000, 16'h8001};
    drain();

    // short window, loose threshold, full smoothing
    ready_mask = 8'b1011_0110;
    set_all(192000, 8, 3, 24'hFFFFFF, 65535, 65535);
    queue_tone(40, 3, 30000, 50);
    drain();

    // oversized window register, then a window shorter than the lag
    write_reg(CFG_WINDOW_LEN, 4095);
    queue_tone(8, 5, 20000, 0);
    drain();
    write_reg(CFG_WINDOW_LEN, 3);
    queue_tone(8, 2, 32767, 0);
    drain();

    // largest exact window, strict threshold
    write_reg(CFG_WINDOW_LEN, 2048);
    write_reg(CFG_DIP_THRESHOLD, 0);
    queue_tone(6, 4, 10000, 10);
    drain();

    // min lag below three, zero rate, then smallest rate
    set_all(0, 6, 1, 24'h00C000, 0, 0);
    queue_tone(18, 2, 32000, 0);
    drain();
    set_all(1, 6, 2, 24'h00C000, 65535, 0);
    queue_tone(18, 3, 32000, 100);
    drain();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      ready_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : $urandom_range(1, 255);
      win = $urandom_range(3, 40);
      set_all($urandom_range(0, 2) == 0 ? 192000 : $urandom_range(1, 192000),
              win, $urandom_range(1, win),
              $urandom_range(0, 3) == 0 ? 24'hFFFFFF : $urandom_range(0, 24'h30000),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
      for (int b = 0; b < 4; b++) begin
        per = $urandom_range(2, (win / 2 > 2) ? win / 2 : 2);
        if ($urandom_range(0, 4) == 0)
          queue_tone(6, 0, 0, 32767);
        else
          queue_tone(6, per, $urandom_range(100, 32767), $urandom_range(0, 300));
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (err_count == 0 && pitch_queue.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ yin_pitch_estimator.f @@
hw/rtl/ype_pkg.sv
hw/rtl/yin_pitch_estimator.sv
tb/tb_top.sv
